@@ design/sitrd_pkg.sv @@
// ----------------------------------------------------------------------------
// sitrd_pkg
// Shared widths, constants and types of the signed integer to radix digits
// converter.
// ----------------------------------------------------------------------------
package sitrd_pkg;

	localparam int VALUE_W    = 32;
	localparam int SYM_W      = 8;
	localparam int RADIX_W    = 5;
	localparam int DIGIT_W    = 4;
	localparam int MAX_BASE   = 16;
	localparam int MAX_DIGITS = 32;
	localparam int IDX_W      = $clog2(MAX_DIGITS);
	localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
	localparam int BITS_W     = $clog2(VALUE_W + 1);
	localparam int PADDR_W    = 5;
	localparam int PDATA_W    = 64;

	localparam logic [RADIX_W-1:0] RADIX_RST        = 5'd10;
	localparam logic [63:0]        SYMBOLS_LOW_RST  = 64'h3736_3534_3332_3130;
	localparam logic [63:0]        SYMBOLS_HIGH_RST = 64'h4645_4443_4241_3938;

	localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
	localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;

	typedef logic [MAX_BASE-1:0][SYM_W-1:0]     sym_table_t;
	typedef logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digit_lanes_t;

	typedef struct packed {
		logic [RADIX_W-1:0] radix;
		sym_table_t         symbols;
	} cfg_t;

	typedef struct packed {
		logic             done;
		logic             neg;
		logic [CNT_W-1:0] count;
	} conv_res_t;

endpackage

@@ design/signed_int_to_radix_digits_core.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_radix_digits_core
// Converts a signed 32-bit value into symbol bytes in a configured radix,
// a leading minus for negative values, most significant digit first.
//
//   channel   dir   handshake                     payload
//   value     in    value_valid / value_ready     value[31:0] signed
//   symbol    out   symbol_valid / symbol_ready   symbol[7:0], last
//   apb       in    psel, penable, pwrite, pready paddr[4:0], pwdata/prdata[63:0]
//
// One item is accepted, converted one magnitude bit per cycle into the digit
// lanes, handed over to the emitter, then emitted one symbol at a time (the
// digits plus one for a minus sign). A new value is taken only once the last
// item's symbols are all emitted. An item with an unusable base is dropped
// in its accept cycle. Reset restores radix 10 and symbols "0123456789ABCDEF".
// A stalled output holds the output register and pauses emission.
// ----------------------------------------------------------------------------
module signed_int_to_radix_digits_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [sitrd_pkg::PADDR_W-1:0]     paddr,
	input  logic [sitrd_pkg::PDATA_W-1:0]     pwdata,
	output logic [sitrd_pkg::PDATA_W-1:0]     prdata,
	output logic                              pready,
	input  logic                              value_valid,
	output logic                              value_ready,
	input  logic signed [sitrd_pkg::VALUE_W-1:0] value,
	output logic                              symbol_valid,
	input  logic                              symbol_ready,
	output logic [sitrd_pkg::SYM_W-1:0]       symbol,
	output logic                              last
);

	sitrd_pkg::cfg_t               cfg;
	sitrd_pkg::conv_res_t          res;
	sitrd_pkg::digit_lanes_t       digits;
	logic                          base_ok;
	logic                          conv_busy;
	logic                          emit_busy;
	logic                          start;
	logic                          neg;
	logic [sitrd_pkg::VALUE_W-1:0] mag;

	assign value_ready = !conv_busy && !emit_busy;
	assign start       = value_valid && value_ready && base_ok;
	assign neg         = value[sitrd_pkg::VALUE_W-1];
	assign mag         = neg ? (~$unsigned(value) + 1'b1) : $unsigned(value);

	sitrd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.base_ok (base_ok)
	);

	sitrd_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mag    (mag),
		.neg    (neg),
		.radix  (cfg.radix),
		.busy   (conv_busy),
		.res    (res),
		.digits (digits)
	);

	sitrd_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.res          (res),
		.digits       (digits),
		.symbols      (cfg.symbols),
		.busy         (emit_busy),
		.symbol       (symbol),
		.last         (last),
		.symbol_valid (symbol_valid),
		.symbol_ready (symbol_ready)
	);

endmodule

@@ design/sitrd_regs.sv @@
// ----------------------------------------------------------------------------
// sitrd_regs
// Configuration registers (radix, symbol table) behind the APB port, and the
// check that the radix and the symbols in use form a usable base.
// ----------------------------------------------------------------------------
module sitrd_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [sitrd_pkg::PADDR_W-1:0]     paddr,
	input  logic [sitrd_pkg::PDATA_W-1:0]     pwdata,
	output logic [sitrd_pkg::PDATA_W-1:0]     prdata,
	output logic                              pready,
	output sitrd_pkg::cfg_t                   cfg,
	output logic                              base_ok
);

	typedef enum logic [1:0] {
		REG_RADIX    = 2'd0,
		REG_SYM_LOW  = 2'd1,
		REG_SYM_HIGH = 2'd2
	} reg_sel_t;

	logic [sitrd_pkg::RADIX_W-1:0] radix_q;
	logic [63:0]                   sym_low_q;
	logic [63:0]                   sym_high_q;
	reg_sel_t                      sel;
	logic                          wr_en;
	logic                          bad;
	sitrd_pkg::sym_table_t         sym;

	assign sel     = reg_sel_t'(paddr[sitrd_pkg::PADDR_W-1:3]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign sym     = {sym_high_q, sym_low_q};
	assign cfg     = '{radix: radix_q, symbols: sym};
	assign base_ok = !bad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q    <= sitrd_pkg::RADIX_RST;
			sym_low_q  <= sitrd_pkg::SYMBOLS_LOW_RST;
			sym_high_q <= sitrd_pkg::SYMBOLS_HIGH_RST;
		end else if (wr_en) begin
			case (sel)
				REG_RADIX:    radix_q    <= pwdata[sitrd_pkg::RADIX_W-1:0];
				REG_SYM_LOW:  sym_low_q  <= pwdata;
				REG_SYM_HIGH: sym_high_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			REG_RADIX:    prdata = sitrd_pkg::PDATA_W'(radix_q);
			REG_SYM_LOW:  prdata = sym_low_q;
			REG_SYM_HIGH: prdata = sym_high_q;
			default:      prdata = '0;
		endcase
	end

	always_comb begin
		bad = (radix_q < 5'd2) || (radix_q > sitrd_pkg::RADIX_W'(sitrd_pkg::MAX_BASE));
		for (int i = 0; i < sitrd_pkg::MAX_BASE; i++) begin
			if (sitrd_pkg::RADIX_W'(i) < radix_q) begin
				if (sym[i] == sitrd_pkg::SYM_MINUS || sym[i] == sitrd_pkg::SYM_PLUS)
					bad = 1'b1;
				for (int j = i + 1; j < sitrd_pkg::MAX_BASE; j++) begin
					if (sitrd_pkg::RADIX_W'(j) < radix_q && sym[j] == sym[i])
						bad = 1'b1;
				end
			end
		end
	end

endmodule

@@ design/sitrd_conv.sv @@
// ----------------------------------------------------------------------------
// sitrd_conv
// Bit-serial conversion of the magnitude into radix digit lanes: one bit per
// cycle, MSB first, every lane doubled plus carry, carries resolved as a
// generate/propagate add across the lanes.
// ----------------------------------------------------------------------------
module sitrd_conv (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [sitrd_pkg::VALUE_W-1:0]     mag,
	input  logic                              neg,
	input  logic [sitrd_pkg::RADIX_W-1:0]     radix,
	output logic                              busy,
	output sitrd_pkg::conv_res_t              res,
	output sitrd_pkg::digit_lanes_t           digits
);

	localparam int L = sitrd_pkg::MAX_DIGITS;

	logic                            busy_q;
	logic                            done_q;
	logic                            neg_q;
	logic [sitrd_pkg::BITS_W-1:0]    bits_q;
	logic [sitrd_pkg::CNT_W-1:0]     count_q;
	logic [sitrd_pkg::VALUE_W-1:0]   mag_q;
	sitrd_pkg::digit_lanes_t         digits_q;
	sitrd_pkg::digit_lanes_t         nd;
	logic [L-1:0]                    gen;
	logic [L-1:0]                    prop;
	logic [L:0]                      csum;
	logic [L:0]                      carry;
	logic [sitrd_pkg::RADIX_W-1:0]   t [L];

	assign busy   = busy_q || done_q;
	assign res    = '{done: done_q, neg: neg_q, count: count_q};
	assign digits = digits_q;

	always_comb begin
		for (int k = 0; k < L; k++) begin
			gen[k]  = ({digits_q[k], 1'b0} >= radix);
			prop[k] = ({digits_q[k], 1'b1} == radix);
		end
		csum  = {1'b0, gen | prop} + {1'b0, gen} + (L + 1)'(mag_q[sitrd_pkg::VALUE_W-1]);
		carry = csum ^ {1'b0, gen | prop} ^ {1'b0, gen};
		for (int k = 0; k < L; k++) begin
			t[k]  = {digits_q[k], carry[k]};
			nd[k] = carry[k+1] ? sitrd_pkg::DIGIT_W'(t[k] - radix)
			                   : sitrd_pkg::DIGIT_W'(t[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			bits_q  <= '0;
			count_q <= '0;
		end else begin
			done_q <= !start && busy_q && (bits_q == sitrd_pkg::BITS_W'(1));
			if (start) begin
				busy_q  <= 1'b1;
				bits_q  <= sitrd_pkg::BITS_W'(sitrd_pkg::VALUE_W);
				count_q <= sitrd_pkg::CNT_W'(1);
			end else if (busy_q) begin
				bits_q <= bits_q - 1'b1;
				if (carry[count_q])
					count_q <= count_q + 1'b1;
				if (bits_q == sitrd_pkg::BITS_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q    <= mag;
			neg_q    <= neg;
			digits_q <= '0;
		end else if (busy_q) begin
			mag_q    <= {mag_q[sitrd_pkg::VALUE_W-2:0], 1'b0};
			digits_q <= nd;
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy)
		else $error("conversion started while busy");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (count_q >= sitrd_pkg::CNT_W'(1)
			&& count_q <= sitrd_pkg::CNT_W'(sitrd_pkg::MAX_DIGITS)))
		else $error("digit count out of range");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q))
		else $error("done without a finished conversion");

endmodule

@@ design/sitrd_emit.sv @@
// ----------------------------------------------------------------------------
// sitrd_emit
// Emission of the sign and the digit symbols, most significant first, into
// the output register, one symbol per transfer.
// ----------------------------------------------------------------------------
module sitrd_emit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sitrd_pkg::conv_res_t              res,
	input  sitrd_pkg::digit_lanes_t           digits,
	input  sitrd_pkg::sym_table_t             symbols,
	output logic                              busy,
	output logic [sitrd_pkg::SYM_W-1:0]       symbol,
	output logic                              last,
	output logic                              symbol_valid,
	input  logic                              symbol_ready
);

	logic                            neg_q;
	logic [sitrd_pkg::CNT_W-1:0]     idx_q;
	logic [sitrd_pkg::IDX_W-1:0]     rd_idx;
	logic                            valid_q;
	logic [sitrd_pkg::SYM_W-1:0]     symbol_q;
	logic                            last_q;
	logic                            advance;

	assign busy         = neg_q || (idx_q != '0);
	assign advance      = busy && (!valid_q || symbol_ready);
	assign rd_idx       = sitrd_pkg::IDX_W'(idx_q - 1'b1);
	assign symbol       = symbol_q;
	assign last         = last_q;
	assign symbol_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q   <= 1'b0;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (advance)
				valid_q <= 1'b1;
			else if (symbol_ready)
				valid_q <= 1'b0;
			if (res.done) begin
				neg_q <= res.neg;
				idx_q <= res.count;
			end else if (advance) begin
				if (neg_q)
					neg_q <= 1'b0;
				else
					idx_q <= idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			symbol_q <= neg_q ? sitrd_pkg::SYM_MINUS : symbols[digits[rd_idx]];
			last_q   <= !neg_q && (idx_q == sitrd_pkg::CNT_W'(1));
		end
	end

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |-> !busy)
		else $error("digits handed over while emitting");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> valid_q && last_q)
		else $error("emission ended without a final symbol");

endmodule
